[sv/gbi_pkg.sv]
package gbi_pkg;

    localparam int DEF_MAX_NODES   = 16;
    localparam int DEF_MAX_OUTPUTS = 8;
    localparam int DEF_DATA_WIDTH  = 16;

    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 11;
    localparam int NODE_CNT_W = 5;
    localparam int OUT_CNT_W  = 4;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int OIDX_W     = 3;

    // ratios are Q1.16, one is 1 << FRAC_W
    localparam int FRAC_W  = 16;
    localparam int RATIO_W = FRAC_W + 1;
    localparam logic [RATIO_W-1:0] RATIO_ONE  = RATIO_W'(1) << FRAC_W;
    localparam logic [RATIO_W-1:0] RATIO_ZERO = '0;

    typedef enum logic [OPCODE_W-1:0] {
        OP_EVAL   = 2'd0,
        OP_AXIS1  = 2'd1,
        OP_AXIS2  = 2'd2,
        OP_RULE   = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS1_COUNT = 2'd0,
        CFG_AXIS2_COUNT = 2'd1,
        CFG_OUT_COUNT   = 2'd2,
        CFG_NONE        = 2'd3
    } t_cfg_index;

    typedef enum logic [3:0] {
        S_IDLE,
        S_AX_FIRST,
        S_AX_LAST,
        S_AX_CLAMP,
        S_SEARCH,
        S_PROBE,
        S_RATIO,
        S_DIV,
        S_BASE,
        S_ORIGIN,
        S_FETCH,
        S_LERP,
        S_EMIT
    } t_state;

endpackage

[sv/gbi_mem.sv]
module gbi_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rdata <= r_mem[i_raddr];
    end

endmodule

[sv/gbi_div.sv]
module gbi_div
    import gbi_pkg::*;
#(
    parameter int WIDTH = 17
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [WIDTH-1:0]  i_num,
    input  logic [WIDTH-1:0]  i_den,
    output logic              o_done,
    output logic [FRAC_W-1:0] o_quot
);

    localparam int CNT_W = $clog2(FRAC_W + 1);

    logic [WIDTH:0]     r_rem;
    logic [WIDTH-1:0]   r_den;
    logic [FRAC_W-1:0]  r_quot;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic               r_done;
    logic [WIDTH:0]     shifted;
    logic               fits;

    // numerator is below the divisor, so remainder stays below twice it
    assign shifted = {r_rem[WIDTH-1:0], 1'b0};
    assign fits    = shifted >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(FRAC_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= {1'b0, i_num};
            r_den  <= i_den;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= fits ? (shifted - {1'b0, r_den}) : shifted;
            r_quot <= {r_quot[FRAC_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

`ifndef ASSERT_OFF
    a_done_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(r_busy))
        else $error("divider done without a running division");
    a_no_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> r_rem < {1'b0, r_den})
        else $error("divider remainder not below divisor");
    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("divider done held longer than one cycle");
`endif

endmodule

[sv/grid_table_bilinear_interpolator_core.sv]
// Two-input grid table with bilinear interpolation. Load words (opcodes 1..3) write one
// entry of the axis 1 nodes, axis 2 nodes or rule table and produce nothing; config writes
// set node and output counts. An evaluate word clamps each sample to its axis, binary
// searches its interval and forms a Q1.16 ratio with a 16-step restoring divider, then
// returns one Q8.8 value per output, the final one flagged last. The block works on one
// evaluate at a time: per axis a clamp, a binary search and the division, then address
// setup, and per output four reads from the single rule memory port, then three lerps
// of one multiply and one add each. A load is taken only while the block is idle.
module grid_table_bilinear_interpolator_core
    import gbi_pkg::*;
#(
    parameter int MAX_NODES   = DEF_MAX_NODES,
    parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
    parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,

    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_DATA_W-1:0]        i_cfg_data,

    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [OPCODE_W-1:0]          i_opcode,
    input  logic [INDEX_W-1:0]           i_entry_index,
    input  logic signed [DATA_WIDTH-1:0] i_entry_value,
    input  logic signed [DATA_WIDTH-1:0] i_sample_1,
    input  logic signed [DATA_WIDTH-1:0] i_sample_2,

    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [OIDX_W-1:0]            o_output_index,
    output logic signed [DATA_WIDTH-1:0] o_output_value,
    output logic                         o_last
);

    localparam int DW        = DATA_WIDTH;
    localparam int NW        = $clog2(MAX_NODES);
    localparam int NCW       = $clog2(MAX_NODES + 1);
    localparam int OCW       = $clog2(MAX_OUTPUTS + 1);
    localparam int RULE_DEPTH = MAX_NODES * MAX_NODES * MAX_OUTPUTS;
    localparam int RAW       = $clog2(RULE_DEPTH);
    localparam int PW        = DW + 19;
    localparam logic signed [PW-1:0] ROUND_C = PW'(32768);

    // configuration
    logic [NODE_CNT_W-1:0] r_cfg_n1, r_cfg_n2;
    logic [OUT_CNT_W-1:0]  r_cfg_no;
    logic [NCW-1:0]        n1, n2, n_ax;
    logic [OCW-1:0]        no;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_n1 <= NODE_CNT_W'(2);
            r_cfg_n2 <= NODE_CNT_W'(2);
            r_cfg_no <= OUT_CNT_W'(1);
        end else if (i_cfg_we) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_AXIS1_COUNT: r_cfg_n1 <= i_cfg_data[NODE_CNT_W-1:0];
                CFG_AXIS2_COUNT: r_cfg_n2 <= i_cfg_data[NODE_CNT_W-1:0];
                CFG_OUT_COUNT:   r_cfg_no <= i_cfg_data[OUT_CNT_W-1:0];
                default: ;
            endcase
        end
    end

    assign n1 = (r_cfg_n1 < NODE_CNT_W'(2)) ? NCW'(2) :
                (32'(r_cfg_n1) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(r_cfg_n1);
    assign n2 = (r_cfg_n2 < NODE_CNT_W'(2)) ? NCW'(2) :
                (32'(r_cfg_n2) > MAX_NODES) ? NCW'(MAX_NODES) : NCW'(r_cfg_n2);
    assign no = (r_cfg_no < OUT_CNT_W'(1)) ? OCW'(1) :
                (32'(r_cfg_no) > MAX_OUTPUTS) ? OCW'(MAX_OUTPUTS) : OCW'(r_cfg_no);

    t_state r_state, n_state;

    logic accept;
    assign o_in_stall = (r_state != S_IDLE);
    assign accept     = i_in_valid && !o_in_stall;

    // memories
    logic          ax1_we, ax2_we, rule_we;
    logic [NW-1:0] ax_raddr;
    logic [DW-1:0] ax1_rdata, ax2_rdata;
    logic [RAW-1:0] rule_raddr;
    logic [DW-1:0]  rule_rdata;

    assign ax1_we  = accept && (t_opcode'(i_opcode) == OP_AXIS1) &&
                     (32'(i_entry_index) < MAX_NODES);
    assign ax2_we  = accept && (t_opcode'(i_opcode) == OP_AXIS2) &&
                     (32'(i_entry_index) < MAX_NODES);
    assign rule_we = accept && (t_opcode'(i_opcode) == OP_RULE) &&
                     (32'(i_entry_index) < RULE_DEPTH);

    gbi_mem #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_axis1 (
        .i_clk   (i_clk),
        .i_we    (ax1_we),
        .i_waddr (NW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_raddr (ax_raddr),
        .o_rdata (ax1_rdata)
    );

    gbi_mem #(.DEPTH(MAX_NODES), .WIDTH(DW)) u_axis2 (
        .i_clk   (i_clk),
        .i_we    (ax2_we),
        .i_waddr (NW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_raddr (ax_raddr),
        .o_rdata (ax2_rdata)
    );

    gbi_mem #(.DEPTH(RULE_DEPTH), .WIDTH(DW)) u_rule (
        .i_clk   (i_clk),
        .i_we    (rule_we),
        .i_waddr (RAW'(i_entry_index)),
        .i_wdata (i_entry_value),
        .i_raddr (rule_raddr),
        .o_rdata (rule_rdata)
    );

    // axis search
    logic                 r_ax;
    logic signed [DW-1:0] r_x1, r_x2, x, node;
    logic signed [DW-1:0] r_loval, r_hival;
    logic [NW-1:0]        r_lo, r_hi, r_mid, mid, last_node;
    logic [NW-1:0]        r_i1, r_i2;
    logic [RATIO_W-1:0]   r_r1, r_r2;
    logic signed [DW:0]   num, den;
    logic                 div_start, div_done;
    logic [FRAC_W-1:0]    div_quot;
    logic                 ax_done;
    logic [NW-1:0]        ax_idx;
    logic [RATIO_W-1:0]   ax_ratio;

    assign x         = r_ax ? r_x2 : r_x1;
    assign node      = r_ax ? ax2_rdata : ax1_rdata;
    assign n_ax      = r_ax ? n2 : n1;
    assign last_node = NW'(n_ax - 1'b1);
    assign mid       = r_lo + ((r_hi - r_lo) >> 1);
    assign num       = {x[DW-1], x} - {r_loval[DW-1], r_loval};
    assign den       = {r_hival[DW-1], r_hival} - {r_loval[DW-1], r_loval};

    gbi_div #(.WIDTH(DW + 1)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num),
        .i_den   (den),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // grid addressing and lerp
    logic [RAW-1:0]       r_t, r_stride, r_a00;
    logic [2:0]           r_rc;
    logic [2:0]           r_ls;
    logic [OCW-1:0]       r_k;
    logic signed [DW-1:0] r_v [4];
    logic signed [DW-1:0] r_low, r_high, r_res;
    logic signed [PW-1:0] r_p;
    logic signed [DW-1:0] l_a, l_b;
    logic [RATIO_W-1:0]   l_r;
    logic signed [DW:0]   l_diff;
    logic signed [PW-1:0] l_prod;
    logic [DW+2:0]        l_sum;
    logic                 k_last;

    always_comb begin
        case (r_rc)
            3'd0:    rule_raddr = r_a00;
            3'd1:    rule_raddr = r_a00 + r_stride;
            3'd2:    rule_raddr = r_a00 + RAW'(no);
            default: rule_raddr = r_a00 + r_stride + RAW'(no);
        endcase
    end

    always_comb begin
        case (r_ls[2:1])
            2'd0:    begin l_a = r_v[0]; l_b = r_v[1]; l_r = r_r1; end
            2'd1:    begin l_a = r_v[2]; l_b = r_v[3]; l_r = r_r1; end
            default: begin l_a = r_low;  l_b = r_high; l_r = r_r2; end
        endcase
    end

    assign l_diff = {l_b[DW-1], l_b} - {l_a[DW-1], l_a};
    assign l_prod = l_diff * $signed({1'b0, l_r});
    // floor of p / 65536 is an arithmetic shift
    assign l_sum  = {{3{l_a[DW-1]}}, l_a} + r_p[PW-1:FRAC_W];
    assign k_last = (r_k == no - 1'b1);

    // control
    always_comb begin
        n_state   = r_state;
        ax_raddr  = r_mid;
        div_start = 1'b0;
        ax_done   = 1'b0;
        ax_idx    = '0;
        ax_ratio  = RATIO_ZERO;
        unique case (r_state)
            S_IDLE: begin
                if (accept && t_opcode'(i_opcode) == OP_EVAL) begin
                    n_state = S_AX_FIRST;
                end
            end
            S_AX_FIRST: begin
                ax_raddr = '0;
                n_state  = S_AX_LAST;
            end
            S_AX_LAST: begin
                ax_raddr = last_node;
                n_state  = S_AX_CLAMP;
            end
            S_AX_CLAMP: begin
                if (x <= r_loval) begin
                    ax_done = 1'b1;
                end else if (x >= node) begin
                    ax_done  = 1'b1;
                    ax_idx   = NW'(n_ax - NCW'(2));
                    ax_ratio = RATIO_ONE;
                end else begin
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                ax_raddr = mid;
                n_state  = ((r_hi - r_lo) > NW'(1)) ? S_PROBE : S_RATIO;
            end
            S_PROBE: begin
                n_state = S_SEARCH;
            end
            S_RATIO: begin
                ax_idx = r_lo;
                if (den <= 0 || num <= 0) begin
                    ax_done = 1'b1;
                end else if (num >= den) begin
                    ax_done  = 1'b1;
                    ax_ratio = RATIO_ONE;
                end else begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                ax_idx   = r_lo;
                ax_ratio = {1'b0, div_quot};
                ax_done  = div_done;
            end
            S_BASE:   n_state = S_ORIGIN;
            S_ORIGIN: n_state = S_FETCH;
            S_FETCH: begin
                if (r_rc == 3'd4) begin
                    n_state = S_LERP;
                end
            end
            S_LERP: begin
                if (r_ls == 3'd5) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!o_out_valid || !i_out_stall) begin
                    n_state = k_last ? S_IDLE : S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (ax_done) begin
            n_state = r_ax ? S_BASE : S_AX_FIRST;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ax    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE) begin
                r_ax <= 1'b0;
            end else if (ax_done) begin
                r_ax <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x1 <= i_sample_1;
            r_x2 <= i_sample_2;
        end
        if (ax_done) begin
            if (r_ax) begin
                r_i2 <= ax_idx;
                r_r2 <= ax_ratio;
            end else begin
                r_i1 <= ax_idx;
                r_r1 <= ax_ratio;
            end
        end
        case (r_state)
            S_AX_LAST: r_loval <= node;
            S_AX_CLAMP: begin
                r_hival <= node;
                r_lo    <= '0;
                r_hi    <= last_node;
            end
            S_SEARCH: r_mid <= mid;
            S_PROBE: begin
                if (x < node) begin
                    r_hi    <= r_mid;
                    r_hival <= node;
                end else begin
                    r_lo    <= r_mid;
                    r_loval <= node;
                end
            end
            S_BASE: begin
                r_t      <= RAW'(r_i1) * RAW'(n2) + RAW'(r_i2);
                r_stride <= RAW'(n2) * RAW'(no);
            end
            S_ORIGIN: begin
                r_a00 <= RAW'(r_t * RAW'(no));
                r_k   <= '0;
                r_rc  <= '0;
                r_ls  <= '0;
            end
            S_FETCH: begin
                r_rc <= r_rc + 1'b1;
                if (r_rc != 3'd0) begin
                    r_v[r_rc[1:0] - 2'd1] <= rule_rdata;
                end
            end
            S_LERP: begin
                r_ls <= r_ls + 1'b1;
                if (!r_ls[0]) begin
                    r_p <= l_prod + ROUND_C;
                end else begin
                    case (r_ls[2:1])
                        2'd0:    r_low  <= l_sum[DW-1:0];
                        2'd1:    r_high <= l_sum[DW-1:0];
                        default: r_res  <= l_sum[DW-1:0];
                    endcase
                end
            end
            S_EMIT: begin
                if (!o_out_valid || !i_out_stall) begin
                    r_k   <= r_k + 1'b1;
                    r_a00 <= r_a00 + 1'b1;
                    r_rc  <= '0;
                    r_ls  <= '0;
                end
            end
            default: ;
        endcase
    end

    // output word register
    logic r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && (!r_out_valid || !i_out_stall)) begin
            o_output_index <= OIDX_W'(r_k);
            o_output_value <= r_res;
            o_last         <= k_last;
        end
    end

    assign o_out_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_eval_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_opcode'(i_opcode) == OP_EVAL) |=> r_state == S_AX_FIRST)
        else $error("evaluate word did not start a search");
    a_ratio_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FETCH) |-> (r_r1 <= RATIO_ONE && r_r2 <= RATIO_ONE))
        else $error("interpolation ratio above one");
    a_search_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SEARCH) |-> r_lo < r_hi)
        else $error("search bounds crossed");
    a_div_only_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> (num > 0 && num < den))
        else $error("division started outside the open interval");
    a_load_no_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && t_opcode'(i_opcode) != OP_EVAL) |=> r_state == S_IDLE)
        else $error("load word left idle");
`endif

endmodule

[test/tb_top.sv]
module tb_top;
    import gbi_pkg::*;

    localparam int NODES    = 16;
    localparam int OUTS     = 8;
    localparam int RULES    = NODES * NODES * OUTS;
    localparam int LIMIT    = 2000000;

    typedef struct packed {
        logic [OIDX_W-1:0] oidx;
        logic signed [15:0] value;
        logic               last;
    } t_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OPCODE_W-1:0]  i_opcode;
    logic [INDEX_W-1:0]   i_entry_index;
    logic signed [15:0]   i_entry_value;
    logic signed [15:0]   i_sample_1;
    logic signed [15:0]   i_sample_2;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [OIDX_W-1:0]    o_output_index;
    logic signed [15:0]   o_output_value;
    logic                 o_last;

    grid_table_bilinear_interpolator_core i_dut (.*);

    // shadow state of the block
    logic signed [15:0] ax1_nodes [NODES];
    logic signed [15:0] ax2_nodes [NODES];
    logic signed [15:0] rule_mem [RULES];
    int unsigned n1_cnt, n2_cnt, out_cnt;

    t_result expected_q[$];
    int      send_idle_pct, recv_idle_pct;
    int      errors;
    int      cycles;

    always begin
        i_clk = 1'b0;
        #2;
        i_clk = 1'b1;
        #2;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("grid_table_bilinear_interpolator_core test failed");
            $finish;
        end
    end

    function automatic longint lerp16(longint a, longint b, longint r);
        longint p;
        longint q;
        p = (b - a) * r + 32768;
        if (p >= 0) q = p / 65536;
        else q = -((-p + 65535) / 65536);
        return a + q;
    endfunction

    // interval index, ratio through the output argument
    function automatic int unsigned locate(input logic signed [15:0] nodes [NODES],
                                           int unsigned n, longint x, output longint ratio);
        int unsigned lo, hi, mid;
        longint num, den;
        lo = 0;
        hi = n - 1;
        if (x <= nodes[0]) begin
            ratio = 0;
            return 0;
        end
        if (x >= nodes[n-1]) begin
            ratio = 65536;
            return n - 2;
        end
        while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (x < nodes[mid]) hi = mid;
            else lo = mid;
        end
        num = x - nodes[lo];
        den = longint'(nodes[hi]) - nodes[lo];
        if (den <= 0 || num <= 0) ratio = 0;
        else if (num >= den) ratio = 65536;
        else ratio = (num * 65536) / den;
        return lo;
    endfunction

    task automatic predict_word(t_opcode op, int unsigned idx, logic signed [15:0] val,
                                logic signed [15:0] s1, logic signed [15:0] s2);
        int unsigned n1, n2, no, i1, i2, base, stride, a00;
        longint r1, r2, lowv, highv;
        t_result res;
        case (op)
            OP_AXIS1: if (idx < NODES) ax1_nodes[idx] = val;
            OP_AXIS2: if (idx < NODES) ax2_nodes[idx] = val;
            OP_RULE:  if (idx < RULES) rule_mem[idx] = val;
            default: begin
                n1 = n1_cnt < 2 ? 2 : (n1_cnt > NODES ? NODES : n1_cnt);
                n2 = n2_cnt < 2 ? 2 : (n2_cnt > NODES ? NODES : n2_cnt);
                no = out_cnt < 1 ? 1 : (out_cnt > OUTS ? OUTS : out_cnt);
                i1 = locate(ax1_nodes, n1, s1, r1);
                i2 = locate(ax2_nodes, n2, s2, r2);
                base = (i1 * n2 + i2) * no;
                stride = n2 * no;
                for (int unsigned k = 0; k < no; k++) begin
                    a00 = base + k;
                    lowv = lerp16(rule_mem[a00], rule_mem[a00 + stride], r1);
                    highv = lerp16(rule_mem[a00 + no], rule_mem[a00 + stride + no], r1);
                    res.oidx = k[OIDX_W-1:0];
                    res.value = 16'(lerp16(lowv, highv, r2));
                    res.last = (k + 1 == no);
                    expected_q.push_back(res);
                end
            end
        endcase
    endtask

    // valid stays high after the word so the next one can follow at once
    task automatic send_word(t_opcode op, int unsigned idx, logic signed [15:0] val,
                             logic signed [15:0] s1, logic signed [15:0] s2);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_entry_index <= idx[INDEX_W-1:0];
        i_entry_value <= val;
        i_sample_1    <= s1;
        i_sample_2    <= s2;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_word(op, idx, val, s1, s2);
    endtask

    always @(posedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result idx=%0d value=%0d last=%0b", $time,
                         o_output_index, o_output_value, o_last);
                errors++;
            end else begin
                want = expected_q.pop_front();
                if (want.oidx !== o_output_index || want.value !== o_output_value
                    || want.last !== o_last) begin
                    $display("%0t: mismatch expected idx=%0d value=%0d last=%0b, got idx=%0d value=%0d last=%0b",
                             $time, want.oidx, want.value, want.last,
                             o_output_index, o_output_value, o_last);
                    errors++;
                end
            end
        end
    end

    task automatic drain();
        i_in_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (400) @(posedge i_clk);
    endtask

    // write enable stays high so writes can follow at once
    task automatic write_reg(t_cfg_index idx, int unsigned val);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val[CFG_DATA_W-1:0];
        @(posedge i_clk);
        case (idx)
            CFG_AXIS1_COUNT: n1_cnt = val & 5'h1f;
            CFG_AXIS2_COUNT: n2_cnt = val & 5'h1f;
            CFG_OUT_COUNT:   out_cnt = val & 4'hf;
            default: ;
        endcase
    endtask

    // strictly increasing nodes, axis 1 spread over the full range when wide, random rules
    task automatic load_tables(bit wide);
        int signed v;
        int signed step;
        v = wide ? -32768 : -$urandom_range(2000);
        for (int i = 0; i < NODES; i++) begin
            step = wide ? 4369 : $urandom_range(1, 600);
            send_word(OP_AXIS1, i, 16'(v), '0, '0);
            v += step;
        end
        v = -$urandom_range(3000);
        for (int i = 0; i < NODES; i++) begin
            send_word(OP_AXIS2, i, 16'(v), '0, '0);
            v += $urandom_range(1, 1900);
        end
        for (int i = 0; i < RULES; i++)
            predict_word(OP_RULE, i, 16'($urandom), '0, '0);
    endtask

    // rules go through the block only where the current shape reads them
    task automatic push_rules(int unsigned count);
        for (int unsigned i = 0; i < count; i++)
            send_word(OP_RULE, i, ($urandom_range(3) == 0) ? 16'h8000 : 16'($urandom), '0, '0);
    endtask

    task automatic config_shape(int unsigned n1, int unsigned n2, int unsigned no);
        drain();
        write_reg(CFG_AXIS1_COUNT, n1);
        write_reg(CFG_AXIS2_COUNT, n2);
        write_reg(CFG_OUT_COUNT, no);
        i_cfg_we <= 1'b0;
        push_rules(n1 * n2 * no);
    endtask

    task automatic test_directed();
        logic signed [15:0] xs [5] = '{16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sh0100};
        load_tables(1'b1);
        config_shape(2, 2, 1);
        foreach (xs[i]) send_word(OP_EVAL, 0, '0, xs[i], xs[4 - i]);
        // exact nodes and out-of-range loads
        send_word(OP_EVAL, 0, '0, ax1_nodes[1], ax2_nodes[0]);
        send_word(OP_AXIS1, 2047, 16'sh7fff, '0, '0);
        send_word(OP_AXIS2, 16, 16'sh8000, '0, '0);
        send_word(OP_RULE, 2047, 16'sh5555, '0, '0);
        config_shape(16, 16, 8);
        send_word(OP_EVAL, 0, '0, 16'sh8000, 16'sh7fff);
        send_word(OP_EVAL, 0, '0, 16'sh7fff, 16'sh8000);
        send_word(OP_EVAL, 0, '0, ax1_nodes[7] + 1, ax2_nodes[9] - 1);
        // out of range counts and an unused index
        drain();
        write_reg(CFG_AXIS1_COUNT, 0);
        write_reg(CFG_AXIS2_COUNT, 31);
        write_reg(CFG_OUT_COUNT, 15);
        write_reg(CFG_NONE, 5);
        i_cfg_we <= 1'b0;
        send_word(OP_EVAL, 0, '0, 16'sh1234, -16'sh0234);
        send_word(OP_EVAL, 0, '0, 16'($urandom), 16'($urandom));
    endtask

    task automatic test_random(int unsigned words);
        int unsigned n1, n2, no, sent;
        sent = 0;
        while (sent < words) begin
            n1 = $urandom_range(2, 16);
            n2 = $urandom_range(2, 16);
            no = $urandom_range(1, 8);
            if ($urandom_range(3) == 0) load_tables($urandom_range(1));
            config_shape(n1, n2, no);
            for (int i = 0; i < 15; i++) begin
                if ($urandom_range(9) == 0)
                    send_word(t_opcode'($urandom_range(1, 3)), $urandom_range(16, 2047),
                              16'($urandom), 16'($urandom), 16'($urandom));
                else if ($urandom_range(3) == 0)
                    send_word(OP_EVAL, 0, '0, 16'($urandom), 16'($urandom));
                else
                    send_word(OP_EVAL, $urandom, 16'($urandom),
                              16'(ax1_nodes[0] + $urandom_range(0, 8000) - 200),
                              16'(ax2_nodes[0] + $urandom_range(0, 12000) - 200));
                sent++;
            end
        end
    endtask

    initial begin
        cycles = 0;
        errors = 0;
        send_idle_pct = 16;
        recv_idle_pct = 54;
        n1_cnt = 2;
        n2_cnt = 2;
        out_cnt = 1;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_NONE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_opcode = OP_EVAL;
        i_entry_index = '0;
        i_entry_value = '0;
        i_sample_1 = '0;
        i_sample_2 = '0;
        i_out_stall = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(110);
        send_idle_pct = 54;
        recv_idle_pct = 16;
        test_random(110);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(110);
        drain();
        if (errors == 0 && expected_q.size() == 0)
            $display("grid_table_bilinear_interpolator_core test passed");
        else
            $display("grid_table_bilinear_interpolator_core test failed");
        $finish;
    end
endmodule

[grid_table_bilinear_interpolator_core.f]
sv/gbi_pkg.sv
sv/gbi_mem.sv
sv/gbi_div.sv
sv/grid_table_bilinear_interpolator_core.sv
test/tb_top.sv
